// ----- sv/anbs_pkg.sv -----
// shared types and constants for the annex b nal summary scanner
// used by anbs_classify and annexb_nal_summary_scanner; no dependencies
package anbs_pkg;

	// prefix check status; code 3 is never produced and reads as bad
	typedef enum logic [1:0] {
		PFX_PENDING = 2'd0,
		PFX_GOOD    = 2'd1,
		PFX_BAD     = 2'd2
	} pfx_t;

	// sticky nal flags, one bit per class of header
	typedef struct packed {
		logic key;
		logic pps;
		logic sps;
		logic vps;
	} nal_flags_t;

	localparam int unsigned COUNT_W = 16;
	localparam int unsigned POS_W   = 3;
	localparam int unsigned ZRUN_W  = 2;

	// number of leading bytes the prefix check looks at before saturating
	localparam logic [POS_W-1:0]  POS_MAX  = 3'd4;
	localparam logic [ZRUN_W-1:0] ZRUN_MAX = 2'd2;

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONE  = 8'h01;

	// codec register values
	localparam logic CODEC_H264 = 1'b0;
	localparam logic CODEC_H265 = 1'b1;

	// h.264 nal unit types (5 bits)
	localparam logic [4:0] H264_IDR = 5'd5;
	localparam logic [4:0] H264_SPS = 5'd7;
	localparam logic [4:0] H264_PPS = 5'd8;

	// h.265 nal unit types (6 bits)
	localparam logic [5:0] H265_IRAP_LO = 6'd16;
	localparam logic [5:0] H265_IRAP_HI = 6'd23;
	localparam logic [5:0] H265_VPS     = 6'd32;
	localparam logic [5:0] H265_SPS     = 6'd33;
	localparam logic [5:0] H265_PPS     = 6'd34;

endpackage

// ----- sv/anbs_classify.sv -----
// nal header classifier: maps one header byte to its flag bits by codec
// depends on anbs_pkg
module anbs_classify (
	input  logic                  codec,
	input  logic [7:0]            header,
	output anbs_pkg::nal_flags_t  flags
);

	logic [4:0] avc_type;
	logic [5:0] hevc_type;

	assign avc_type  = header[4:0];
	assign hevc_type = header[6:1];

	always_comb begin
		flags = '0;
		if (codec == anbs_pkg::CODEC_H264) begin
			flags.sps = (avc_type == anbs_pkg::H264_SPS);
			flags.pps = (avc_type == anbs_pkg::H264_PPS);
			flags.key = (avc_type == anbs_pkg::H264_IDR);
		end else begin
			flags.vps = (hevc_type == anbs_pkg::H265_VPS);
			flags.sps = (hevc_type == anbs_pkg::H265_SPS);
			flags.pps = (hevc_type == anbs_pkg::H265_PPS);
			flags.key = (hevc_type inside {[anbs_pkg::H265_IRAP_LO:anbs_pkg::H265_IRAP_HI]});
		end
	end

endmodule

// ----- sv/annexb_nal_summary_scanner.sv -----
// annex b start code scanner with per-buffer nal summary, top level
// depends on anbs_pkg and anbs_classify
//
// usage
//   input channel: one byte of an annex b buffer per item (stream_byte), with
//   end_of_buffer high on the final byte. valid/ready handshake.
//   output channel: one summary item per buffer, issued for the final byte:
//   starts_with_code, unit_count (saturating at 65535) and four sticky flags.
//   a buffer that does not open with 00 00 01 or 00 00 00 01 gives all zeros.
//   config channel: cfg_valid/cfg_ready carrying codec_select (0 h.264,
//   1 h.265); cfg_ready is always high, write only while the block is idle.
// timing
//   an item is held in the input register (_s1), is folded into the
//   scan state by the next-state logic and, for a final byte, lands in the
//   output register, which drives out_valid. one byte per cycle sustained
//   while no final byte waits on a full output slot; the only loop is the
//   scan state update (zero run, prefix check, counter, flags).
// reset and stall
//   arst_n clears the scan state, the codec (h.264) and both valid bits.
//   while a summary waits on out_ready, plain bytes keep flowing; only a
//   second final byte waits in the input register, and in_ready then drops.
module annexb_nal_summary_scanner (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream in
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  stream_byte,
	input  logic        end_of_buffer,
	// summary out
	output logic        out_valid,
	input  logic        out_ready,
	output logic        starts_with_code,
	output logic [15:0] unit_count,
	output logic        saw_vps,
	output logic        saw_sps,
	output logic        saw_pps,
	output logic        saw_keyframe,
	// codec register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        codec_select
);

	localparam int unsigned CW = anbs_pkg::COUNT_W;
	localparam int unsigned PW = anbs_pkg::POS_W;
	localparam int unsigned ZW = anbs_pkg::ZRUN_W;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eob_s1;

	// configuration
	logic codec_q;

	// scan state
	logic [ZW-1:0]        zero_run_q, zero_run_d;
	logic                 hdr_pend_q, hdr_pend_d;
	logic [PW-1:0]        pos_q, pos_d;
	anbs_pkg::pfx_t       pfx_q, pfx_d;
	logic [CW-1:0]        count_q, count_d;
	anbs_pkg::nal_flags_t flags_q, flags_d;
	anbs_pkg::nal_flags_t hdr_flags;

	// output register
	logic                 out_valid_q;
	logic                 starts_q;
	logic [CW-1:0]        count_out_q;
	anbs_pkg::nal_flags_t flags_out_q;

	logic out_free;
	logic s1_fire;
	logic in_fire;
	logic good_d;

	// a final byte needs a free output slot, any other byte always proceeds
	assign out_free = !out_valid_q || out_ready;
	assign s1_fire  = valid_s1 && (!eob_s1 || out_free);
	assign in_ready = !valid_s1 || s1_fire;
	assign in_fire  = in_valid && in_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codec_q <= anbs_pkg::CODEC_H264;
		end else if (cfg_valid) begin
			codec_q <= codec_select;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= stream_byte;
			eob_s1  <= end_of_buffer;
		end
	end

	// header byte classification
	anbs_classify u_classify (
		.codec  (codec_q),
		.header (byte_s1),
		.flags  (hdr_flags)
	);

	// scan state next values for the byte in the input register
	always_comb begin
		pfx_d      = pfx_q;
		pos_d      = pos_q;
		zero_run_d = zero_run_q;
		hdr_pend_d = hdr_pend_q;
		count_d    = count_q;
		flags_d    = flags_q;

		// prefix check over the first four bytes
		if (pfx_q == anbs_pkg::PFX_PENDING) begin
			case (pos_q) inside
				3'd0, 3'd1: begin
					if (byte_s1 != anbs_pkg::BYTE_ZERO) pfx_d = anbs_pkg::PFX_BAD;
				end
				3'd2: begin
					if (byte_s1 == anbs_pkg::BYTE_ONE) pfx_d = anbs_pkg::PFX_GOOD;
					else if (byte_s1 != anbs_pkg::BYTE_ZERO) pfx_d = anbs_pkg::PFX_BAD;
				end
				3'd3: begin
					pfx_d = (byte_s1 == anbs_pkg::BYTE_ONE) ? anbs_pkg::PFX_GOOD
					                                        : anbs_pkg::PFX_BAD;
				end
				default: begin
					pfx_d = anbs_pkg::PFX_BAD;
				end
			endcase
		end
		if (pos_q < anbs_pkg::POS_MAX) pos_d = pos_q + PW'(1);

		// start code detection; the header byte never starts a zero run
		if (hdr_pend_q) begin
			if (count_q != {CW{1'b1}}) count_d = count_q + CW'(1);
			flags_d    = flags_q | hdr_flags;
			hdr_pend_d = 1'b0;
			zero_run_d = '0;
		end else if (byte_s1 == anbs_pkg::BYTE_ZERO) begin
			if (zero_run_q < anbs_pkg::ZRUN_MAX) zero_run_d = zero_run_q + ZW'(1);
		end else begin
			hdr_pend_d = (byte_s1 == anbs_pkg::BYTE_ONE) && (zero_run_q >= anbs_pkg::ZRUN_MAX);
			zero_run_d = '0;
		end
	end

	// only a good prefix unmasks the summary; pending or bad give zeros
	assign good_d = (pfx_d == anbs_pkg::PFX_GOOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_run_q <= '0;
			hdr_pend_q <= 1'b0;
			pos_q      <= '0;
			pfx_q      <= anbs_pkg::PFX_PENDING;
			count_q    <= '0;
			flags_q    <= '0;
		end else if (s1_fire) begin
			if (eob_s1) begin
				// buffer done: back to the reset state for the next one
				zero_run_q <= '0;
				hdr_pend_q <= 1'b0;
				pos_q      <= '0;
				pfx_q      <= anbs_pkg::PFX_PENDING;
				count_q    <= '0;
				flags_q    <= '0;
			end else begin
				zero_run_q <= zero_run_d;
				hdr_pend_q <= hdr_pend_d;
				pos_q      <= pos_d;
				pfx_q      <= pfx_d;
				count_q    <= count_d;
				flags_q    <= flags_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && eob_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && eob_s1) begin
			starts_q    <= good_d;
			count_out_q <= good_d ? count_d : '0;
			flags_out_q <= good_d ? flags_d : '0;
		end
	end

	assign out_valid        = out_valid_q;
	assign starts_with_code = starts_q;
	assign unit_count       = count_out_q;
	assign saw_vps          = flags_out_q.vps;
	assign saw_sps          = flags_out_q.sps;
	assign saw_pps          = flags_out_q.pps;
	assign saw_keyframe     = flags_out_q.key;

`ifndef SYNTH
	// a bad or undecided prefix must mask the whole summary
	a_bad_prefix_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !starts_q |-> count_out_q == '0 && flags_out_q == '0)
		else $error("summary not cleared for bad prefix");

	// a pending header always follows a reset zero run
	a_hdr_zero_run: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_pend_q |-> zero_run_q == '0)
		else $error("zero run live while header pending");

	// the final byte of a buffer returns the scan state to reset
	a_eob_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire && eob_s1 |=> count_q == '0 && pos_q == '0 && !hdr_pend_q
			&& pfx_q == anbs_pkg::PFX_PENDING)
		else $error("scan state not cleared after final byte");

	// the counter moves only when a byte is processed
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_fire |=> $stable(count_q))
		else $error("unit counter changed without a byte");

	// the output slot is never overwritten while its summary waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !(s1_fire && eob_s1))
		else $error("pending summary overwritten");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench for annexb_nal_summary_scanner: a directed table, then random buffers
// summaries are predicted in place as bytes are accepted; needs anbs_pkg and the scanner rtl
module testbench;

	// run limits: a correct run is about 2k items plus stalls
	localparam int unsigned CYCLE_LIMIT     = 200_000;
	localparam int unsigned DRAIN_CYCLES    = 8;
	localparam int unsigned PHASE_ITEMS     = 480;
	localparam int unsigned HOLD_OFF_AT     = 20;
	localparam int unsigned HOLD_OFF_CYCLES = 240;

	// one summary as it leaves the block
	typedef struct packed {
		logic        starts;
		logic [15:0] units;
		logic        vps;
		logic        sps;
		logic        pps;
		logic        key;
	} nal_summary_t;

	// one stimulus item; typed rows carry their summary written out by hand
	typedef struct packed {
		logic [7:0]   b;
		logic         last;
		logic         typed;
		nal_summary_t want;
	} scan_row_t;

	localparam nal_summary_t NO_SUMMARY = '0;
	localparam nal_summary_t ONE_SPS    = '{starts: 1'b1, units: 16'd1, vps: 1'b0,
		sps: 1'b1, pps: 1'b0, key: 1'b0};

	// directed part, all under h.264 straight after reset
	localparam int unsigned DIR_ROWS = 24;
	localparam scan_row_t DIR_TAB [DIR_ROWS] = '{
		// a single zero byte: the buffer ends before its prefix is decided
		'{8'h00, 1'b1, 1'b1, NO_SUMMARY},
		// top byte value, no start code at the head
		'{8'hff, 1'b1, 1'b1, NO_SUMMARY},
		// three-byte prefix and one h.264 sps header
		'{8'h00, 1'b0, 1'b0, NO_SUMMARY},
		'{8'h00, 1'b0, 1'b0, NO_SUMMARY},
		'{8'h01, 1'b0, 1'b0, NO_SUMMARY},
		'{8'h67, 1'b1, 1'b1, ONE_SPS},
		// four-byte prefix, header byte of zero; the 00 01 behind it is no start code
		'{8'h00, 1'b0, 1'b0, NO_SUMMARY},
		'{8'h00, 1'b0, 1'b0, NO_SUMMARY},
		'{8'h00, 1'b0, 1'b0, NO_SUMMARY},
		'{8'h01, 1'b0, 1'b0, NO_SUMMARY},
		'{8'h00, 1'b0, 1'b0, NO_SUMMARY},
		'{8'h00, 1'b0, 1'b0, NO_SUMMARY},
		'{8'h01, 1'b0, 1'b0, NO_SUMMARY},
		'{8'h65, 1'b1, 1'b0, NO_SUMMARY},
		// pps header, then a start code on the final bytes with no header after it
		'{8'h00, 1'b0, 1'b0, NO_SUMMARY},
		'{8'h00, 1'b0, 1'b0, NO_SUMMARY},
		'{8'h01, 1'b0, 1'b0, NO_SUMMARY},
		'{8'h68, 1'b0, 1'b0, NO_SUMMARY},
		'{8'h00, 1'b0, 1'b0, NO_SUMMARY},
		'{8'h00, 1'b0, 1'b0, NO_SUMMARY},
		'{8'h01, 1'b1, 1'b0, NO_SUMMARY},
		// prefix broken on its third byte
		'{8'h00, 1'b0, 1'b0, NO_SUMMARY},
		'{8'h00, 1'b0, 1'b0, NO_SUMMARY},
		'{8'h02, 1'b1, 1'b1, NO_SUMMARY}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  stream_byte;
	logic        end_of_buffer;
	logic        out_valid;
	logic        out_ready;
	logic        starts_with_code;
	logic [15:0] unit_count;
	logic        saw_vps;
	logic        saw_sps;
	logic        saw_pps;
	logic        saw_keyframe;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        codec_select;

	annexb_nal_summary_scanner u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.stream_byte      (stream_byte),
		.end_of_buffer    (end_of_buffer),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.starts_with_code (starts_with_code),
		.unit_count       (unit_count),
		.saw_vps          (saw_vps),
		.saw_sps          (saw_sps),
		.saw_pps          (saw_pps),
		.saw_keyframe     (saw_keyframe),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.codec_select     (codec_select)
	);

	// items still to send, summaries still owed by the block
	scan_row_t    stim_q[$];
	nal_summary_t due_summaries[$];
	int unsigned  errors;
	int unsigned  results_seen;
	int unsigned  burst_left;

	// scan state as the block should hold it
	logic                 m_codec;
	logic [1:0]           m_zeros;
	logic                 m_hdr_due;
	logic [2:0]           m_pos;
	anbs_pkg::pfx_t       m_pfx;
	logic [15:0]          m_units;
	anbs_pkg::nal_flags_t m_seen;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// back to the state of a fresh buffer; the codec is kept
	task automatic clear_scan_state();
		m_zeros   = '0;
		m_hdr_due = 1'b0;
		m_pos     = '0;
		m_pfx     = anbs_pkg::PFX_PENDING;
		m_units   = '0;
		m_seen    = '0;
	endtask

	// fold one accepted byte into the scan state; on a final byte hand back the summary
	task automatic predict_summary(input logic [7:0] b, input logic last,
		output logic got, output nal_summary_t s);
		logic [4:0] t264;
		logic [5:0] t265;
		got = 1'b0;
		s   = '0;
		// prefix check over the first four bytes
		if (m_pfx == anbs_pkg::PFX_PENDING) begin
			case (m_pos)
				3'd0, 3'd1: begin
					if (b != anbs_pkg::BYTE_ZERO) m_pfx = anbs_pkg::PFX_BAD;
				end
				3'd2: begin
					if (b == anbs_pkg::BYTE_ONE) m_pfx = anbs_pkg::PFX_GOOD;
					else if (b != anbs_pkg::BYTE_ZERO) m_pfx = anbs_pkg::PFX_BAD;
				end
				3'd3: begin
					m_pfx = (b == anbs_pkg::BYTE_ONE) ? anbs_pkg::PFX_GOOD
					                                  : anbs_pkg::PFX_BAD;
				end
				default: begin
					m_pfx = anbs_pkg::PFX_BAD;
				end
			endcase
		end
		if (m_pos < anbs_pkg::POS_MAX) m_pos = m_pos + 3'd1;
		// header byte right after a start code; it never opens a zero run
		if (m_hdr_due) begin
			if (m_units != 16'hffff) m_units = m_units + 16'd1;
			t264 = b[4:0];
			t265 = b[6:1];
			if (m_codec == anbs_pkg::CODEC_H264) begin
				if (t264 == anbs_pkg::H264_SPS) m_seen.sps = 1'b1;
				if (t264 == anbs_pkg::H264_PPS) m_seen.pps = 1'b1;
				if (t264 == anbs_pkg::H264_IDR) m_seen.key = 1'b1;
			end else begin
				if (t265 == anbs_pkg::H265_VPS) m_seen.vps = 1'b1;
				if (t265 == anbs_pkg::H265_SPS) m_seen.sps = 1'b1;
				if (t265 == anbs_pkg::H265_PPS) m_seen.pps = 1'b1;
				if (t265 >= anbs_pkg::H265_IRAP_LO && t265 <= anbs_pkg::H265_IRAP_HI)
					m_seen.key = 1'b1;
			end
			m_hdr_due = 1'b0;
			m_zeros   = '0;
		end else if (b == anbs_pkg::BYTE_ZERO) begin
			if (m_zeros < anbs_pkg::ZRUN_MAX) m_zeros = m_zeros + 2'd1;
		end else begin
			if (b == anbs_pkg::BYTE_ONE && m_zeros >= anbs_pkg::ZRUN_MAX) m_hdr_due = 1'b1;
			m_zeros = '0;
		end
		if (last) begin
			got = 1'b1;
			if (m_pfx == anbs_pkg::PFX_GOOD)
				s = '{1'b1, m_units, m_seen.vps, m_seen.sps, m_seen.pps, m_seen.key};
			clear_scan_state();
		end
	endtask

	task automatic push_byte(input logic [7:0] b, input logic last);
		stim_q.push_back('{b, last, 1'b0, NO_SUMMARY});
	endtask

	// payload byte, leaning towards zeros and ones so that start codes turn up inside
	function automatic logic [7:0] pick_payload();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 3) return anbs_pkg::BYTE_ZERO;
		if (r == 3) return anbs_pkg::BYTE_ONE;
		return 8'($urandom);
	endfunction

	// header byte, leaning towards the types that set a flag under the given codec
	function automatic logic [7:0] pick_header(input logic codec);
		logic [7:0] hb;
		logic [5:0] t;
		hb = 8'($urandom);
		t  = 6'($urandom_range(0, 63));
		if ($urandom_range(0, 19) == 0) return anbs_pkg::BYTE_ZERO;
		if ($urandom_range(0, 9) < 6) begin
			if (codec == anbs_pkg::CODEC_H264) begin
				case ($urandom_range(0, 3))
					0: t = {1'b0, anbs_pkg::H264_SPS};
					1: t = {1'b0, anbs_pkg::H264_PPS};
					2: t = {1'b0, anbs_pkg::H264_IDR};
					default: t = 6'($urandom_range(0, 31));
				endcase
				hb = {hb[7:5], t[4:0]};
			end else begin
				case ($urandom_range(0, 4))
					0: t = anbs_pkg::H265_VPS;
					1: t = anbs_pkg::H265_SPS;
					2: t = anbs_pkg::H265_PPS;
					3: t = 6'($urandom_range(anbs_pkg::H265_IRAP_LO - 1,
						anbs_pkg::H265_IRAP_HI + 1));
					default: t = 6'($urandom_range(0, 63));
				endcase
				hb = {hb[7], t, hb[0]};
			end
		end
		return hb;
	endfunction

	// one random buffer: mostly well formed, the rest noise or a broken prefix
	task automatic build_buffer(input logic codec);
		int unsigned kind;
		int unsigned n_units;
		kind = $urandom_range(0, 99);
		if (kind < 75) begin
			if ($urandom_range(0, 1) == 1) push_byte(anbs_pkg::BYTE_ZERO, 1'b0);
			push_byte(anbs_pkg::BYTE_ZERO, 1'b0);
			push_byte(anbs_pkg::BYTE_ZERO, 1'b0);
			push_byte(anbs_pkg::BYTE_ONE, 1'b0);
			n_units = $urandom_range(1, 4);
			for (int u = 0; u < n_units; u++) begin
				if (u != 0) begin
					// zero runs longer than two are held at two
					repeat ($urandom_range(2, 4)) push_byte(anbs_pkg::BYTE_ZERO, 1'b0);
					push_byte(anbs_pkg::BYTE_ONE, 1'b0);
				end
				push_byte(pick_header(codec), 1'b0);
				repeat ($urandom_range(0, 8)) push_byte(pick_payload(), 1'b0);
			end
			// now and then a start code right at the end
			if ($urandom_range(0, 9) == 0) begin
				push_byte(anbs_pkg::BYTE_ZERO, 1'b0);
				push_byte(anbs_pkg::BYTE_ZERO, 1'b0);
				push_byte(anbs_pkg::BYTE_ONE, 1'b0);
			end
		end else if (kind < 88) begin
			repeat ($urandom_range(1, 12)) push_byte(pick_payload(), 1'b0);
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					push_byte(anbs_pkg::BYTE_ZERO, 1'b0);
					push_byte(anbs_pkg::BYTE_ONE, 1'b0);
				end
				1: begin
					repeat (4) push_byte(anbs_pkg::BYTE_ZERO, 1'b0);
					push_byte(anbs_pkg::BYTE_ONE, 1'b0);
				end
				2: begin
					repeat ($urandom_range(1, 3)) push_byte(anbs_pkg::BYTE_ZERO, 1'b0);
				end
				default: begin
					repeat (3) push_byte(anbs_pkg::BYTE_ZERO, 1'b0);
					push_byte(8'($urandom_range(2, 255)), 1'b0);
				end
			endcase
			repeat ($urandom_range(0, 4)) push_byte(pick_payload(), 1'b0);
		end
		stim_q[stim_q.size() - 1].last = 1'b1;
	endtask

	// sender: bursts of random length with random gaps, predicting as each item is taken
	task automatic send_rows();
		scan_row_t    row;
		int unsigned  gap;
		logic         got;
		nal_summary_t s;
		while (stim_q.size() != 0) begin
			row = stim_q.pop_front();
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 32);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
				repeat (gap) begin
					@(negedge clk);
					in_valid <= 1'b0;
				end
			end
			burst_left--;
			@(negedge clk);
			in_valid      <= 1'b1;
			stream_byte   <= row.b;
			end_of_buffer <= row.last;
			do @(posedge clk); while (!in_ready);
			predict_summary(row.b, row.last, got, s);
			if (got) due_summaries.push_back(row.typed ? row.want : s);
		end
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// every owed summary has come out, and the last bytes have had time to settle
	task automatic wait_idle();
		while (due_summaries.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// codec register write, only ever between buffers with the block idle
	task automatic write_codec(input logic v);
		wait_idle();
		@(negedge clk);
		cfg_valid    <= 1'b1;
		codec_select <= v;
		do @(posedge clk); while (!cfg_ready);
		m_codec = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// output side: every accepted summary against the oldest one owed
	always @(posedge clk) begin : summary_check
		nal_summary_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			results_seen++;
			if (due_summaries.size() == 0) begin
				$error("summary item with none expected");
				errors++;
			end else begin
				want = due_summaries.pop_front();
				check_field("starts_with_code", 16'(want.starts), 16'(starts_with_code));
				check_field("unit_count", want.units, unit_count);
				check_field("saw_vps", 16'(want.vps), 16'(saw_vps));
				check_field("saw_sps", 16'(want.sps), 16'(saw_sps));
				check_field("saw_pps", 16'(want.pps), 16'(saw_pps));
				check_field("saw_keyframe", 16'(want.key), 16'(saw_keyframe));
			end
		end
	end

	// receiver: its own randomly redrawn stall pattern, plus one long hold-off
	// while the sender keeps offering, so that a second final byte backs up the input
	initial begin : receiver
		int unsigned mode;
		int unsigned left;
		int unsigned hold;
		logic [15:0] pat;
		bit          held;
		mode = 0;
		left = 0;
		hold = 0;
		pat  = '1;
		held = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_seen >= HOLD_OFF_AT) begin
				held = 1'b1;
				hold = HOLD_OFF_CYCLES;
			end
			if (hold != 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				if (left == 0) begin
					left = 64;
					mode = $urandom_range(0, 3);
					pat  = 16'($urandom) | 16'h0001;
				end
				left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: begin
						out_ready <= pat[0];
						pat = {pat[0], pat[15:1]};
					end
				endcase
			end
		end
	end

	// cycle limit on the whole run
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// main sequence: reset, directed table, then random phases across codec settings
	initial begin : main_seq
		logic codec_plan [4];
		codec_plan    = '{anbs_pkg::CODEC_H265, anbs_pkg::CODEC_H264,
			anbs_pkg::CODEC_H265, anbs_pkg::CODEC_H264};
		errors        = 0;
		results_seen  = 0;
		burst_left    = 0;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		stream_byte   = '0;
		end_of_buffer = 1'b0;
		cfg_valid     = 1'b0;
		codec_select  = anbs_pkg::CODEC_H264;
		m_codec       = anbs_pkg::CODEC_H264;
		clear_scan_state();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed rows, codec still at its reset value
		foreach (DIR_TAB[i]) stim_q.push_back(DIR_TAB[i]);
		send_rows();

		for (int p = 0; p < 4; p++) begin
			write_codec(codec_plan[p]);
			while (stim_q.size() < PHASE_ITEMS) build_buffer(codec_plan[p]);
			send_rows();
		end

		wait_idle();
		if (due_summaries.size() != 0) begin
			$error("%0d summaries never arrived", due_summaries.size());
			errors++;
		end
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
